// ===== hdl/eis_pkg.sv =====
// eis_pkg: shared widths, constants and types of the epipolar inlier scorer
// used by every module under hdl; no dependencies
`default_nettype none

package eis_pkg;

  localparam int CoordW     = 24;
  localparam int CoefW      = 32;
  localparam int LineW      = 40;
  localparam int WordW      = 64;
  localparam int ProdW      = 128;
  localparam int DenW       = 80;
  localparam int DistW      = 41;
  localparam int DivSteps   = 40;
  localparam int DigitW     = 16;
  localparam int Digits     = WordW / DigitW;
  localparam int LineShift  = 18;
  localparam int ScoreW     = 32;
  localparam int PtsW       = 20;
  localparam int GainW      = 19;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 64;
  localparam int InDataW    = 96;
  localparam int OutDataW   = 56;
  localparam int QueueDepth = 2;

  localparam logic [ProdW-1:0] ChiTh   = ProdW'(251724);
  localparam logic [GainW-1:0] ScoreTh = GainW'(392626);
  localparam logic [CfgDataW-1:0] InvSigmaReset = CfgDataW'(65536);

  // register indexes, the last two are unused
  typedef enum logic [CfgIdxW-1:0] {
    CfgPairA  = 3'd0,
    CfgPairB  = 3'd1,
    CfgPairC  = 3'd2,
    CfgPairD  = 3'd3,
    CfgLast   = 3'd4,
    CfgInv    = 3'd5,
    CfgSpare6 = 3'd6,
    CfgSpare7 = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic                     last;
    logic signed [CoordW-1:0] v_second;
    logic signed [CoordW-1:0] u_second;
    logic signed [CoordW-1:0] v_first;
    logic signed [CoordW-1:0] u_first;
  } item_t;

  typedef struct packed {
    logic                    start;
    logic signed [WordW-1:0] op_a;
    logic signed [WordW-1:0] op_b;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ProdW-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic [ProdW-1:0] num;
    logic [DenW-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DistW-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/epipolar_inlier_scorer_top.sv =====
// epipolar_inlier_scorer_top: one correspondence in, one score result out
// items are processed one at a time, faster when a line normal is zero or a
// distance hits its cap; the pace is set by the shared 64x16 digit multiplier (twelve
// products per side) and the 40-step divider; a two-deep queue takes new items meanwhile
// reset: score zero, coefficients zero, inverse sigma squared one, queue empty
// depends on eis_pkg, eis_front, eis_back
`default_nettype none

module epipolar_inlier_scorer_top #(
  parameter int QueueDepth = eis_pkg::QueueDepth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [eis_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [eis_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // u_first, v_first, u_second, v_second
  input  wire logic [eis_pkg::InDataW-1:0]   s_axis_tdata,
  input  wire logic                          s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // inlier, point_score, total_score, zero pad
  output logic [eis_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic                               m_axis_tlast
);

  logic           pop, avail;
  eis_pkg::item_t item;

  eis_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .pop_i         (pop),
    .avail_o       (avail),
    .item_o        (item)
  );

  eis_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .avail_i       (avail),
    .item_i        (item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== hdl/eis_front.sv =====
// eis_front: accepts correspondences from the input stream into a short queue
// depends on eis_pkg
`default_nettype none

module eis_front #(
  parameter int Depth = eis_pkg::QueueDepth
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // u_first, v_first, u_second, v_second
  input  wire logic [eis_pkg::InDataW-1:0]  s_axis_tdata,
  input  wire logic                         s_axis_tlast,
  input  wire logic                         pop_i,
  output logic                              avail_o,
  output eis_pkg::item_t                    item_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  eis_pkg::item_t      mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                push;
  eis_pkg::item_t      item_in;

  assign s_axis_tready = (count_q != CntW'(Depth));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign avail_o       = (count_q != '0);
  assign item_o        = mem_q[rd_ptr_q];

  always_comb begin
    item_in.u_first  = s_axis_tdata[23:0];
    item_in.v_first  = s_axis_tdata[47:24];
    item_in.u_second = s_axis_tdata[71:48];
    item_in.v_second = s_axis_tdata[95:72];
    item_in.last     = s_axis_tlast;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/eis_mul.sv =====
// eis_mul: signed 64x64 multiplier, one 16-bit digit of the second operand a cycle
// depends on eis_pkg
`default_nettype none

module eis_mul (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire eis_pkg::mul_req_t req_i,
  output eis_pkg::mul_rsp_t rsp_o
);

  localparam int W   = eis_pkg::WordW;
  localparam int DW  = eis_pkg::DigitW;
  localparam int PPW = W + DW;
  localparam int CW  = $clog2(eis_pkg::Digits);

  logic                         busy_q, done_q, neg_q;
  logic [CW-1:0]                cnt_q;
  logic [W-1:0]                 mag_a_q, mag_b_q;
  logic [eis_pkg::ProdW-1:0]    prod_q;
  logic [PPW-1:0]               pp;
  logic [W-1:0]                 abs_a, abs_b;

  assign abs_a = req_i.op_a[W-1] ? W'(-req_i.op_a) : W'(req_i.op_a);
  assign abs_b = req_i.op_b[W-1] ? W'(-req_i.op_b) : W'(req_i.op_b);
  assign pp    = PPW'(mag_a_q) * PPW'(mag_b_q[W-1 -: DW]);

  assign rsp_o.done = done_q;
  assign rsp_o.prod = neg_q ? -$signed(prod_q) : $signed(prod_q);

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mag_a_q <= abs_a;
      mag_b_q <= abs_b;
      neg_q   <= req_i.op_a[W-1] ^ req_i.op_b[W-1];
      prod_q  <= '0;
    end else if (busy_q) begin
      prod_q  <= (prod_q << DW) + eis_pkg::ProdW'(pp);
      mag_b_q <= mag_b_q << DW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(eis_pkg::Digits - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/eis_div.sv =====
// eis_div: restoring divider for the squared distance, one quotient bit a cycle
// depends on eis_pkg
`default_nettype none

module eis_div (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire eis_pkg::div_req_t req_i,
  output eis_pkg::div_rsp_t rsp_o
);

  localparam int PW = eis_pkg::ProdW;
  localparam int QW = eis_pkg::DistW;
  localparam int CW = $clog2(eis_pkg::DivSteps);

  logic            busy_q, done_q;
  logic [CW-1:0]   cnt_q;
  logic [PW-1:0]   rem_q, dvs_q;
  logic [QW-1:0]   quo_q;
  logic [PW-1:0]   cap;
  logic            capped, ge;

  assign cap    = PW'(req_i.den) << eis_pkg::DivSteps;
  assign capped = (req_i.num >= cap);
  assign ge     = (rem_q >= dvs_q);

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.num;
      dvs_q <= PW'(req_i.den) << (eis_pkg::DivSteps - 1);
      quo_q <= capped ? (QW'(1) << eis_pkg::DivSteps) : '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dvs_q;
      end
      dvs_q <= dvs_q >> 1;
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= CW'(eis_pkg::DivSteps - 1);
        if (capped) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/eis_back.sv =====
// eis_back: configuration registers, per-side sequencer, score accumulator, output
// depends on eis_pkg, eis_mul, eis_div
`default_nettype none

module eis_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [eis_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [eis_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                          avail_i,
  input  wire eis_pkg::item_t                item_i,
  output logic                               pop_o,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [eis_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic                               m_axis_tlast
);

  localparam int W  = eis_pkg::WordW;
  localparam int LW = eis_pkg::LineW;
  localparam int CW = eis_pkg::CoefW;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_ISSUE     = 6'b000010,
    S_WAIT      = 6'b000100,
    S_DIV_ISSUE = 6'b001000,
    S_DIV_WAIT  = 6'b010000,
    S_OUT       = 6'b100000
  } state_e;

  localparam logic [3:0] OpLine0A = 4'd0;
  localparam logic [3:0] OpLine0B = 4'd1;
  localparam logic [3:0] OpLine1A = 4'd2;
  localparam logic [3:0] OpLine1B = 4'd3;
  localparam logic [3:0] OpLine2A = 4'd4;
  localparam logic [3:0] OpLine2B = 4'd5;
  localparam logic [3:0] OpNumX   = 4'd6;
  localparam logic [3:0] OpNumY   = 4'd7;
  localparam logic [3:0] OpNumSq  = 4'd8;
  localparam logic [3:0] OpDenA   = 4'd9;
  localparam logic [3:0] OpDenB   = 4'd10;
  localparam logic [3:0] OpChi    = 4'd11;

  logic signed [CW-1:0]  f_q [3][3];
  logic [31:0]           inv_q;

  state_e                state_q;
  logic [3:0]            op_q;
  logic                  side_q;
  eis_pkg::item_t        item_q;
  logic signed [W-1:0]   acc_q, num_q;
  logic signed [LW-1:0]  line_q [3];
  logic [eis_pkg::ProdW-1:0] n2_q;
  logic [eis_pkg::DenW-1:0]  den_q;
  logic [eis_pkg::DistW-1:0] dist_q;
  logic [eis_pkg::GainW-1:0] gain_q [2];
  logic                  ok_q [2];
  logic [eis_pkg::ScoreW-1:0] score_q;

  logic                  out_valid_q, out_inlier_q, out_last_q;
  logic [eis_pkg::PtsW-1:0]   out_pts_q;
  logic [eis_pkg::ScoreW-1:0] out_total_q;

  eis_pkg::mul_req_t     mul_req;
  eis_pkg::mul_rsp_t     mul_rsp;
  eis_pkg::div_req_t     div_req;
  eis_pkg::div_rsp_t     div_rsp;

  logic [1:0]            k_idx;
  logic                  j_idx;
  logic signed [CW-1:0]  coef_sel, coef_c;
  logic signed [eis_pkg::CoordW-1:0] px, py, ex, ey;
  logic signed [W-1:0]   prod_lo, line_sum, num_sum;
  logic [eis_pkg::DenW-1:0] den_sum;
  logic                  chi_ok;
  logic [eis_pkg::GainW-1:0] gain_now;
  logic [eis_pkg::PtsW-1:0]  pts;
  logic [eis_pkg::ScoreW:0]  total_wide;
  logic [eis_pkg::ScoreW-1:0] total;
  logic                  out_load, out_fire;

  eis_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  eis_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          f_q[r][c] <= '0;
        end
      end
      inv_q <= eis_pkg::InvSigmaReset[31:0];
    end else if (cfg_we_i) begin
      unique case (eis_pkg::cfg_idx_e'(cfg_idx_i))
        eis_pkg::CfgPairA: begin
          f_q[0][0] <= cfg_wdata_i[63:32];
          f_q[0][1] <= cfg_wdata_i[31:0];
        end
        eis_pkg::CfgPairB: begin
          f_q[0][2] <= cfg_wdata_i[63:32];
          f_q[1][0] <= cfg_wdata_i[31:0];
        end
        eis_pkg::CfgPairC: begin
          f_q[1][1] <= cfg_wdata_i[63:32];
          f_q[1][2] <= cfg_wdata_i[31:0];
        end
        eis_pkg::CfgPairD: begin
          f_q[2][0] <= cfg_wdata_i[63:32];
          f_q[2][1] <= cfg_wdata_i[31:0];
        end
        eis_pkg::CfgLast:  f_q[2][2] <= cfg_wdata_i[31:0];
        eis_pkg::CfgInv:   inv_q <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  // operand selection: side 0 maps first-image point to a line in the second image
  assign k_idx = op_q[2:1];
  assign j_idx = op_q[0];
  assign px = side_q ? item_q.u_second : item_q.u_first;
  assign py = side_q ? item_q.v_second : item_q.v_first;
  assign ex = side_q ? item_q.u_first  : item_q.u_second;
  assign ey = side_q ? item_q.v_first  : item_q.v_second;

  always_comb begin
    coef_sel = '0;
    coef_c   = '0;
    for (int r = 0; r < 3; r++) begin
      if (k_idx == 2'(r)) begin
        coef_sel = side_q ? (j_idx ? f_q[1][r] : f_q[0][r])
                          : (j_idx ? f_q[r][1] : f_q[r][0]);
        coef_c   = side_q ? f_q[2][r] : f_q[r][2];
      end
    end
  end

  always_comb begin
    mul_req.start = (state_q == S_ISSUE);
    mul_req.op_a  = '0;
    mul_req.op_b  = '0;
    case (op_q)
      OpLine0A, OpLine1A, OpLine2A: begin
        mul_req.op_a = W'(coef_sel);
        mul_req.op_b = W'(px);
      end
      OpLine0B, OpLine1B, OpLine2B: begin
        mul_req.op_a = W'(coef_sel);
        mul_req.op_b = W'(py);
      end
      OpNumX: begin
        mul_req.op_a = W'(line_q[0]);
        mul_req.op_b = W'(ex);
      end
      OpNumY: begin
        mul_req.op_a = W'(line_q[1]);
        mul_req.op_b = W'(ey);
      end
      OpNumSq: begin
        mul_req.op_a = num_q;
        mul_req.op_b = num_q;
      end
      OpDenA: begin
        mul_req.op_a = W'(line_q[0]);
        mul_req.op_b = W'(line_q[0]);
      end
      OpDenB: begin
        mul_req.op_a = W'(line_q[1]);
        mul_req.op_b = W'(line_q[1]);
      end
      OpChi: begin
        mul_req.op_a = $signed(W'(dist_q));
        mul_req.op_b = $signed(W'(inv_q));
      end
      default: ;
    endcase
  end

  assign div_req.start = (state_q == S_DIV_ISSUE);
  assign div_req.num   = n2_q;
  assign div_req.den   = den_q;

  assign prod_lo  = $signed(mul_rsp.prod[W-1:0]);
  assign line_sum = acc_q + prod_lo + (W'(coef_c) <<< 8);
  assign num_sum  = acc_q + prod_lo + (W'(line_q[2]) <<< 8);
  assign den_sum  = den_q + mul_rsp.prod[eis_pkg::DenW-1:0];
  assign chi_ok   = ($unsigned(mul_rsp.prod) >> 16) <= eis_pkg::ChiTh;
  assign gain_now = eis_pkg::ScoreTh - mul_rsp.prod[34:16];

  assign pts        = eis_pkg::PtsW'(gain_q[0]) + eis_pkg::PtsW'(gain_q[1]);
  assign total_wide = {1'b0, score_q} + (eis_pkg::ScoreW + 1)'(pts);
  assign total      = total_wide[eis_pkg::ScoreW] ? '1 : total_wide[eis_pkg::ScoreW-1:0];

  assign pop_o    = (state_q == S_IDLE) && avail_i;
  assign out_fire = out_valid_q && m_axis_tready;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= item_i;
    end
    if (state_q == S_WAIT && mul_rsp.done) begin
      case (op_q)
        OpLine0A, OpLine1A, OpLine2A, OpNumX: acc_q <= prod_lo;
        OpLine0B, OpLine1B, OpLine2B: line_q[k_idx] <= LW'(line_sum >>> eis_pkg::LineShift);
        OpNumY:  num_q <= num_sum;
        OpNumSq: n2_q  <= mul_rsp.prod;
        OpDenA:  den_q <= mul_rsp.prod[eis_pkg::DenW-1:0];
        OpDenB:  den_q <= den_sum;
        OpChi: begin
          ok_q[side_q]   <= chi_ok;
          gain_q[side_q] <= chi_ok ? gain_now : '0;
        end
        default: ;
      endcase
      if (op_q == OpDenB && den_sum == '0) begin
        ok_q[side_q]   <= 1'b0;
        gain_q[side_q] <= '0;
      end
    end
    if (state_q == S_DIV_WAIT && div_rsp.done) begin
      dist_q <= div_rsp.quot;
    end
    if (out_load) begin
      out_inlier_q <= ok_q[0] && ok_q[1];
      out_pts_q    <= pts;
      out_total_q  <= total;
      out_last_q   <= item_q.last;
    end
  end

  // sequencer and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OpLine0A;
      side_q      <= 1'b0;
      score_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        score_q     <= item_q.last ? '0 : total;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (avail_i) begin
            side_q  <= 1'b0;
            op_q    <= OpLine0A;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: state_q <= S_WAIT;
        S_WAIT: begin
          if (mul_rsp.done) begin
            if ((op_q == OpDenB && den_sum == '0) || op_q == OpChi) begin
              op_q <= OpLine0A;
              if (side_q) begin
                state_q <= S_OUT;
              end else begin
                side_q  <= 1'b1;
                state_q <= S_ISSUE;
              end
            end else if (op_q == OpDenB) begin
              state_q <= S_DIV_ISSUE;
            end else begin
              op_q    <= op_q + 1'b1;
              state_q <= S_ISSUE;
            end
          end
        end
        S_DIV_ISSUE: state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            op_q    <= OpChi;
            state_q <= S_ISSUE;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_total_q, out_pts_q, out_inlier_q};
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == S_ISSUE && op_q == OpLine0A && !side_q)
    else $error("item taken outside idle");

  a_zero_den_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT && mul_rsp.done && op_q == OpDenB && den_sum == '0)
      |=> !ok_q[$past(side_q)] && gain_q[$past(side_q)] == '0)
    else $error("zero line normal passed");

  a_set_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && item_q.last) |=> score_q == '0)
    else $error("score not cleared at set end");

  a_pts_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_pts_q <= eis_pkg::PtsW'(785252))
    else $error("point score out of range");
`endif

endmodule

`default_nettype wire
